### src/q2e_pkg.sv
// Shared constants, angle table and side-band type for the quaternion to heading core.
`default_nettype none

package q2e_pkg;

    localparam int QUAT_WIDTH_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FIELD_WIDTH      = 16;
    localparam int NUM_LANES        = 3;
    localparam int ATAN_MAX_STEPS   = 24;
    localparam int ANG_WIDTH        = 34;
    localparam int XY_WIDTH         = 33;
    localparam int DEG_WIDTH        = 18;
    localparam int ROOT_WIDTH       = 61;
    localparam int SIN_WIDTH        = 32;
    localparam int SQRT_CELLS       = 31;
    localparam int NORM_TOP         = 28;
    localparam int NORM_CELLS       = 6;
    localparam int DEG_SCALE        = 36000;
    localparam int ROLL_LIM         = 18000;
    localparam int PITCH_LIM        = 9000;
    localparam int FULL_TURN_CD     = 36000;

    localparam logic signed [ANG_WIDTH-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ANG_WIDTH-1:0] QUARTER_TURN = 34'sd1073741824;

    localparam logic [31:0] ATAN_TAB [ATAN_MAX_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic                         fix;
        logic signed [ANG_WIDTH-1:0]  base;
    } q2e_ang_t;

endpackage

`default_nettype wire

### src/q2e_sqrt_cell.sv
// One digit cell of the pipelined integer square root, with payload carried alongside.
`default_nettype none

module q2e_sqrt_cell #(
    parameter int BIT_POS = 60,
    parameter int PLW     = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              i_valid,
    output logic                                   i_ready,
    input  wire logic [q2e_pkg::ROOT_WIDTH-1:0]    i_rem,
    input  wire logic [q2e_pkg::ROOT_WIDTH-1:0]    i_root,
    input  wire logic [PLW-1:0]                    i_pl,
    output logic                                   o_valid,
    input  wire logic                              o_ready,
    output logic [q2e_pkg::ROOT_WIDTH-1:0]         o_rem,
    output logic [q2e_pkg::ROOT_WIDTH-1:0]         o_root,
    output logic [PLW-1:0]                         o_pl
);
    import q2e_pkg::*;

    localparam logic [ROOT_WIDTH-1:0] BITV = ROOT_WIDTH'(1) << BIT_POS;

    logic                  valid_reg;
    logic [ROOT_WIDTH-1:0] rem_reg, rem_next;
    logic [ROOT_WIDTH-1:0] root_reg, root_next;
    logic [PLW-1:0]        pl_reg;
    logic [ROOT_WIDTH-1:0] trial;

    assign i_ready = !valid_reg || o_ready;
    assign trial   = i_root + BITV;

    always_comb begin
        if (i_rem >= trial) begin
            rem_next  = i_rem - trial;
            root_next = (i_root >> 1) + BITV;
        end else begin
            rem_next  = i_rem;
            root_next = i_root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (i_ready) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_ready && i_valid) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pl_reg   <= i_pl;
        end
    end

    assign o_valid = valid_reg;
    assign o_rem   = rem_reg;
    assign o_root  = root_reg;
    assign o_pl    = pl_reg;

endmodule

`default_nettype wire

### src/q2e_norm_cell.sv
// One binary-search normalizing cell: shift both operands by a fixed power of two.
`default_nettype none

module q2e_norm_cell #(
    parameter int P  = 32,
    parameter int NW = 34
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     i_valid,
    output logic                          i_ready,
    input  wire logic signed [NW-1:0]     i_x [q2e_pkg::NUM_LANES],
    input  wire logic signed [NW-1:0]     i_y [q2e_pkg::NUM_LANES],
    input  wire logic [NW-1:0]            i_m [q2e_pkg::NUM_LANES],
    input  wire q2e_pkg::q2e_ang_t        i_side [q2e_pkg::NUM_LANES],
    output logic                          o_valid,
    input  wire logic                     o_ready,
    output logic signed [NW-1:0]          o_x [q2e_pkg::NUM_LANES],
    output logic signed [NW-1:0]          o_y [q2e_pkg::NUM_LANES],
    output logic [NW-1:0]                 o_m [q2e_pkg::NUM_LANES],
    output q2e_pkg::q2e_ang_t             o_side [q2e_pkg::NUM_LANES]
);
    import q2e_pkg::*;

    localparam int RSH   = NORM_TOP + P;
    localparam bit HAS_L = (P <= NORM_TOP);
    localparam int LSH   = HAS_L ? (NORM_TOP + 1 - P) : 0;

    logic                 valid_reg;
    logic signed [NW-1:0] x_reg [NUM_LANES];
    logic signed [NW-1:0] x_next [NUM_LANES];
    logic signed [NW-1:0] y_reg [NUM_LANES];
    logic signed [NW-1:0] y_next [NUM_LANES];
    logic [NW-1:0]        m_reg [NUM_LANES];
    logic [NW-1:0]        m_next [NUM_LANES];
    q2e_ang_t             side_reg [NUM_LANES];

    assign i_ready = !valid_reg || o_ready;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            x_next[l] = i_x[l];
            y_next[l] = i_y[l];
            m_next[l] = i_m[l];
            if ((i_m[l] >> RSH) != '0) begin
                x_next[l] = i_x[l] >>> P;
                y_next[l] = i_y[l] >>> P;
                m_next[l] = i_m[l] >> P;
            end else if (HAS_L && ((i_m[l] >> LSH) == '0)) begin
                x_next[l] = i_x[l] <<< P;
                y_next[l] = i_y[l] <<< P;
                m_next[l] = i_m[l] << P;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (i_ready) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_ready && i_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            m_reg    <= m_next;
            side_reg <= i_side;
        end
    end

    assign o_valid = valid_reg;
    assign o_x     = x_reg;
    assign o_y     = y_reg;
    assign o_m     = m_reg;
    assign o_side  = side_reg;

endmodule

`default_nettype wire

### src/q2e_cordic_cell.sv
// One vectoring CORDIC iteration for all lanes.
`default_nettype none

module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   i_valid,
    output logic                                        i_ready,
    input  wire logic signed [q2e_pkg::XY_WIDTH-1:0]    i_x [q2e_pkg::NUM_LANES],
    input  wire logic signed [q2e_pkg::XY_WIDTH-1:0]    i_y [q2e_pkg::NUM_LANES],
    input  wire logic signed [q2e_pkg::ANG_WIDTH-1:0]   i_z [q2e_pkg::NUM_LANES],
    input  wire q2e_pkg::q2e_ang_t                      i_side [q2e_pkg::NUM_LANES],
    output logic                                        o_valid,
    input  wire logic                                   o_ready,
    output logic signed [q2e_pkg::XY_WIDTH-1:0]         o_x [q2e_pkg::NUM_LANES],
    output logic signed [q2e_pkg::XY_WIDTH-1:0]         o_y [q2e_pkg::NUM_LANES],
    output logic signed [q2e_pkg::ANG_WIDTH-1:0]        o_z [q2e_pkg::NUM_LANES],
    output q2e_pkg::q2e_ang_t                           o_side [q2e_pkg::NUM_LANES]
);
    import q2e_pkg::*;

    localparam logic signed [ANG_WIDTH-1:0] STEP_ANG = $signed(ANG_WIDTH'(ATAN_TAB[STEP]));

    logic                        valid_reg;
    logic signed [XY_WIDTH-1:0]  x_reg [NUM_LANES];
    logic signed [XY_WIDTH-1:0]  x_next [NUM_LANES];
    logic signed [XY_WIDTH-1:0]  y_reg [NUM_LANES];
    logic signed [XY_WIDTH-1:0]  y_next [NUM_LANES];
    logic signed [ANG_WIDTH-1:0] z_reg [NUM_LANES];
    logic signed [ANG_WIDTH-1:0] z_next [NUM_LANES];
    q2e_ang_t                    side_reg [NUM_LANES];

    assign i_ready = !valid_reg || o_ready;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (!i_y[l][XY_WIDTH-1]) begin
                x_next[l] = i_x[l] + (i_y[l] >>> STEP);
                y_next[l] = i_y[l] - (i_x[l] >>> STEP);
                z_next[l] = i_z[l] + STEP_ANG;
            end else begin
                x_next[l] = i_x[l] - (i_y[l] >>> STEP);
                y_next[l] = i_y[l] + (i_x[l] >>> STEP);
                z_next[l] = i_z[l] - STEP_ANG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (i_ready) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_ready && i_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= i_side;
        end
    end

    assign o_valid = valid_reg;
    assign o_x     = x_reg;
    assign o_y     = y_reg;
    assign o_z     = z_reg;
    assign o_side  = side_reg;

endmodule

`default_nettype wire

### src/q2e_atan2.sv
// Three-lane pipelined atan2: quadrant fold, normalize, CORDIC chain, scale to hundredths.
`default_nettype none

module q2e_atan2 #(
    parameter int NW    = 34,
    parameter int STEPS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   i_valid,
    output logic                                        i_ready,
    input  wire logic signed [NW-1:0]                   i_y [q2e_pkg::NUM_LANES],
    input  wire logic signed [NW-1:0]                   i_x [q2e_pkg::NUM_LANES],
    output logic                                        o_valid,
    input  wire logic                                   o_ready,
    output logic signed [q2e_pkg::DEG_WIDTH-1:0]        o_ang [q2e_pkg::NUM_LANES]
);
    import q2e_pkg::*;

    localparam int PRODW = ANG_WIDTH + 18;
    localparam logic signed [17:0]       DEG_K = 18'(DEG_SCALE);
    localparam logic signed [PRODW-1:0]  RND   = PRODW'(HALF_TURN);

    // fold stage
    logic                 pv_reg;
    logic                 prdy;
    logic signed [NW-1:0] px_reg [NUM_LANES];
    logic signed [NW-1:0] px_next [NUM_LANES];
    logic signed [NW-1:0] py_reg [NUM_LANES];
    logic signed [NW-1:0] py_next [NUM_LANES];
    logic [NW-1:0]        pm_reg [NUM_LANES];
    logic [NW-1:0]        pm_next [NUM_LANES];
    logic [NW-1:0]        ax [NUM_LANES];
    logic [NW-1:0]        ay [NUM_LANES];
    q2e_ang_t             ps_reg [NUM_LANES];
    q2e_ang_t             ps_next [NUM_LANES];

    // normalize chain
    logic                 nv [NORM_CELLS+1];
    logic                 nr [NORM_CELLS+1];
    logic signed [NW-1:0] nx [NORM_CELLS+1][NUM_LANES];
    logic signed [NW-1:0] ny [NORM_CELLS+1][NUM_LANES];
    logic [NW-1:0]        nm [NORM_CELLS+1][NUM_LANES];
    q2e_ang_t             ns [NORM_CELLS+1][NUM_LANES];

    // CORDIC chain
    logic                        cv [STEPS+1];
    logic                        cr [STEPS+1];
    logic signed [XY_WIDTH-1:0]  cx [STEPS+1][NUM_LANES];
    logic signed [XY_WIDTH-1:0]  cy [STEPS+1][NUM_LANES];
    logic signed [ANG_WIDTH-1:0] cz [STEPS+1][NUM_LANES];
    q2e_ang_t                    cs [STEPS+1][NUM_LANES];

    // scale stages
    logic                        h1v_reg, h1rdy;
    logic                        h2v_reg, h2rdy;
    logic signed [ANG_WIDTH-1:0] ang [NUM_LANES];
    logic signed [PRODW-1:0]     prod_reg [NUM_LANES];
    logic signed [PRODW-1:0]     prod_next [NUM_LANES];
    logic signed [PRODW-1:0]     hr [NUM_LANES];
    logic signed [DEG_WIDTH-1:0] deg_reg [NUM_LANES];
    logic signed [DEG_WIDTH-1:0] deg_next [NUM_LANES];

    assign prdy    = !pv_reg || nr[0];
    assign i_ready = prdy;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            px_next[l]      = i_x[l];
            py_next[l]      = i_y[l];
            ps_next[l].fix  = 1'b0;
            ps_next[l].base = '0;
            if (i_y[l] == '0) begin
                ps_next[l].fix  = 1'b1;
                ps_next[l].base = (i_x[l] < 0) ? HALF_TURN : '0;
            end else if (i_x[l] == '0) begin
                ps_next[l].fix  = 1'b1;
                ps_next[l].base = (i_y[l] > 0) ? QUARTER_TURN : -QUARTER_TURN;
            end else if (i_x[l] < 0) begin
                ps_next[l].base = (i_y[l] > 0) ? HALF_TURN : -HALF_TURN;
                px_next[l]      = -i_x[l];
                py_next[l]      = -i_y[l];
            end
            ax[l]      = px_next[l][NW-1] ? $unsigned(-px_next[l]) : $unsigned(px_next[l]);
            ay[l]      = py_next[l][NW-1] ? $unsigned(-py_next[l]) : $unsigned(py_next[l]);
            pm_next[l] = (ax[l] > ay[l]) ? ax[l] : ay[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (prdy) begin
            pv_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prdy && i_valid) begin
            px_reg <= px_next;
            py_reg <= py_next;
            pm_reg <= pm_next;
            ps_reg <= ps_next;
        end
    end

    assign nv[0] = pv_reg;
    assign nx[0] = px_reg;
    assign ny[0] = py_reg;
    assign nm[0] = pm_reg;
    assign ns[0] = ps_reg;

    for (genvar k = 0; k < NORM_CELLS; k++) begin : g_norm
        q2e_norm_cell #(
            .P  (32 >> k),
            .NW (NW)
        ) u_norm (
            .aclk    (aclk),
            .aresetn (aresetn),
            .i_valid (nv[k]),
            .i_ready (nr[k]),
            .i_x     (nx[k]),
            .i_y     (ny[k]),
            .i_m     (nm[k]),
            .i_side  (ns[k]),
            .o_valid (nv[k+1]),
            .o_ready (nr[k+1]),
            .o_x     (nx[k+1]),
            .o_y     (ny[k+1]),
            .o_m     (nm[k+1]),
            .o_side  (ns[k+1])
        );
    end

    assign cv[0]            = nv[NORM_CELLS];
    assign nr[NORM_CELLS]   = cr[0];
    assign cs[0]            = ns[NORM_CELLS];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            cx[0][l] = XY_WIDTH'(nx[NORM_CELLS][l]);
            cy[0][l] = XY_WIDTH'(ny[NORM_CELLS][l]);
            cz[0][l] = '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        q2e_cordic_cell #(
            .STEP (k)
        ) u_cordic (
            .aclk    (aclk),
            .aresetn (aresetn),
            .i_valid (cv[k]),
            .i_ready (cr[k]),
            .i_x     (cx[k]),
            .i_y     (cy[k]),
            .i_z     (cz[k]),
            .i_side  (cs[k]),
            .o_valid (cv[k+1]),
            .o_ready (cr[k+1]),
            .o_x     (cx[k+1]),
            .o_y     (cy[k+1]),
            .o_z     (cz[k+1]),
            .o_side  (cs[k+1])
        );
    end

    assign h2rdy     = !h2v_reg || o_ready;
    assign h1rdy     = !h1v_reg || h2rdy;
    assign cr[STEPS] = h1rdy;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            ang[l]       = cs[STEPS][l].fix ? cs[STEPS][l].base
                                            : cs[STEPS][l].base + cz[STEPS][l];
            prod_next[l] = PRODW'(ang[l]) * PRODW'(DEG_K);
            hr[l]        = (prod_reg[l] + RND) >>> 32;
            deg_next[l]  = DEG_WIDTH'(hr[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1v_reg <= 1'b0;
            h2v_reg <= 1'b0;
        end else begin
            if (h1rdy) begin
                h1v_reg <= cv[STEPS];
            end
            if (h2rdy) begin
                h2v_reg <= h1v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (h1rdy && cv[STEPS]) begin
            prod_reg <= prod_next;
        end
        if (h2rdy && h1v_reg) begin
            deg_reg <= deg_next;
        end
    end

    assign o_valid = h2v_reg;
    assign o_ang   = deg_reg;

endmodule

`default_nettype wire

### src/quaternion_to_euler_heading_core.sv
// Top level: quaternion to roll, pitch and heading in hundredths of a degree.
// Pipeline from input beat to result beat:
//   4 matrix/square stages, 31 square-root cells, 1 fold, 6 normalize cells,
//   CORDIC_STEPS iteration cells, 2 scale stages and the output register.
// Throughput: one beat per cycle while m_ready keeps up; every stage has its own valid and ready.
// Reset: synchronous, active low; clears all valid bits and sets declination to 0.
`default_nettype none

module quaternion_to_euler_heading_core #(
    parameter int QUAT_WIDTH   = q2e_pkg::QUAT_WIDTH_DEF,
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic signed [15:0]                    cfg_wr_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [q2e_pkg::FIELD_WIDTH-1:0] s_quat_w,
    input  wire logic signed [q2e_pkg::FIELD_WIDTH-1:0] s_quat_x,
    input  wire logic signed [q2e_pkg::FIELD_WIDTH-1:0] s_quat_y,
    input  wire logic signed [q2e_pkg::FIELD_WIDTH-1:0] s_quat_z,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [15:0]                         m_roll_angle,
    output logic signed [14:0]                         m_pitch_angle,
    output logic [15:0]                                m_heading_angle
);
    import q2e_pkg::*;

    localparam int Q    = QUAT_WIDTH;
    localparam int TW   = 2 * Q;
    localparam int NW   = ((TW > SIN_WIDTH) ? TW : SIN_WIDTH) + 2;
    localparam int PLW  = 4 * TW + SIN_WIDTH;
    localparam int SH   = 2 * Q - 36;
    localparam int RSH  = (SH > 0) ? SH : 0;
    localparam int LSH  = (SH < 0) ? -SH : 0;
    localparam int EW   = DEG_WIDTH + 2;
    localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< (2 * Q - 6);
    localparam logic [63:0] SQ_ONE = 64'd1 << 60;

    logic signed [15:0] decl_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, ov_reg;
    logic rdy1, rdy2, rdy3, rdy4, out_rdy;

    logic [31:0]         ew, ex, ey, ez;
    logic signed [Q-1:0] qw, qx, qy, qz;

    logic signed [TW-1:0] pww_reg, pxx_reg, pyy_reg, pzz_reg, pwz_reg;
    logic signed [TW-1:0] pxy_reg, pxz_reg, pwy_reg, pwx_reg, pyz_reg;
    logic signed [TW-1:0] a11_reg, a33_reg, a21_reg, a31_reg, a32_reg;
    logic signed [TW-1:0] b11_reg, b33_reg, b21_reg, b32_reg;
    logic signed [TW-1:0] c11_reg, c33_reg, c21_reg, c32_reg;
    logic signed [TW-1:0] s_cl;
    logic signed [SIN_WIDTH-1:0] s3_reg, s3_next, s4_reg;
    logic signed [63:0]   sq;
    logic [ROOT_WIDTH-1:0] n4_reg, n4_next;

    logic                  sv [SQRT_CELLS+1];
    logic                  sr [SQRT_CELLS+1];
    logic [ROOT_WIDTH-1:0] srem [SQRT_CELLS+1];
    logic [ROOT_WIDTH-1:0] sroot [SQRT_CELLS+1];
    logic [PLW-1:0]        spl [SQRT_CELLS+1];

    logic signed [NW-1:0]        at_y [NUM_LANES];
    logic signed [NW-1:0]        at_x [NUM_LANES];
    logic signed [DEG_WIDTH-1:0] at_ang [NUM_LANES];
    logic                        at_valid;

    logic signed [DEG_WIDTH:0]   pitch_neg;
    logic signed [EW-1:0]        head_sum, head_adj;
    logic signed [15:0]          roll_reg, roll_next;
    logic signed [14:0]          pitch_reg, pitch_next;
    logic [15:0]                 head_reg, head_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decl_reg <= '0;
        end else if (cfg_wr_en) begin
            decl_reg <= cfg_wr_data;
        end
    end

    assign out_rdy = !ov_reg || m_ready;
    assign rdy4    = !v4_reg || sr[0];
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign ew = {16'd0, s_quat_w};
    assign ex = {16'd0, s_quat_x};
    assign ey = {16'd0, s_quat_y};
    assign ez = {16'd0, s_quat_z};
    assign qw = (Q > FIELD_WIDTH) ? $signed(ew[Q-1:0]) : $signed(Q'(s_quat_w));
    assign qx = (Q > FIELD_WIDTH) ? $signed(ex[Q-1:0]) : $signed(Q'(s_quat_x));
    assign qy = (Q > FIELD_WIDTH) ? $signed(ey[Q-1:0]) : $signed(Q'(s_quat_y));
    assign qz = (Q > FIELD_WIDTH) ? $signed(ez[Q-1:0]) : $signed(Q'(s_quat_z));

    assign s_cl    = (a31_reg > ONE_T) ? ONE_T : ((a31_reg < -ONE_T) ? -ONE_T : a31_reg);
    assign s3_next = SIN_WIDTH'(s_cl >>> RSH) <<< LSH;
    assign sq      = 64'(s3_reg) * 64'(s3_reg);
    assign n4_next = ROOT_WIDTH'(SQ_ONE - $unsigned(sq));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            pww_reg <= TW'(qw) * TW'(qw);
            pxx_reg <= TW'(qx) * TW'(qx);
            pyy_reg <= TW'(qy) * TW'(qy);
            pzz_reg <= TW'(qz) * TW'(qz);
            pwz_reg <= TW'(qw) * TW'(qz);
            pxy_reg <= TW'(qx) * TW'(qy);
            pxz_reg <= TW'(qx) * TW'(qz);
            pwy_reg <= TW'(qw) * TW'(qy);
            pwx_reg <= TW'(qw) * TW'(qx);
            pyz_reg <= TW'(qy) * TW'(qz);
        end
        if (rdy2 && v1_reg) begin
            a11_reg <= (pww_reg >>> 2) + (pxx_reg >>> 2) - (pyy_reg >>> 2) - (pzz_reg >>> 2);
            a33_reg <= (pww_reg >>> 2) - (pxx_reg >>> 2) - (pyy_reg >>> 2) + (pzz_reg >>> 2);
            a21_reg <= (pwz_reg >>> 1) + (pxy_reg >>> 1);
            a31_reg <= (pxz_reg >>> 1) - (pwy_reg >>> 1);
            a32_reg <= (pwx_reg >>> 1) + (pyz_reg >>> 1);
        end
        if (rdy3 && v2_reg) begin
            s3_reg  <= s3_next;
            b11_reg <= a11_reg;
            b33_reg <= a33_reg;
            b21_reg <= a21_reg;
            b32_reg <= a32_reg;
        end
        if (rdy4 && v3_reg) begin
            n4_reg  <= n4_next;
            s4_reg  <= s3_reg;
            c11_reg <= b11_reg;
            c33_reg <= b33_reg;
            c21_reg <= b21_reg;
            c32_reg <= b32_reg;
        end
    end

    assign sv[0]    = v4_reg;
    assign srem[0]  = n4_reg;
    assign sroot[0] = '0;
    assign spl[0]   = {c32_reg, c33_reg, c21_reg, c11_reg, s4_reg};

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        q2e_sqrt_cell #(
            .BIT_POS (ROOT_WIDTH - 1 - 2 * k),
            .PLW     (PLW)
        ) u_sqrt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .i_valid (sv[k]),
            .i_ready (sr[k]),
            .i_rem   (srem[k]),
            .i_root  (sroot[k]),
            .i_pl    (spl[k]),
            .o_valid (sv[k+1]),
            .o_ready (sr[k+1]),
            .o_rem   (srem[k+1]),
            .o_root  (sroot[k+1]),
            .o_pl    (spl[k+1])
        );
    end

    assign at_y[0] = NW'($signed(spl[SQRT_CELLS][PLW-1 -: TW]));
    assign at_x[0] = NW'($signed(spl[SQRT_CELLS][PLW-1-TW -: TW]));
    assign at_y[2] = NW'($signed(spl[SQRT_CELLS][PLW-1-2*TW -: TW]));
    assign at_x[2] = NW'($signed(spl[SQRT_CELLS][PLW-1-3*TW -: TW]));
    assign at_y[1] = NW'($signed(spl[SQRT_CELLS][SIN_WIDTH-1:0]));
    assign at_x[1] = NW'($signed({1'b0, sroot[SQRT_CELLS][30:0]}));

    q2e_atan2 #(
        .NW    (NW),
        .STEPS (CORDIC_STEPS)
    ) u_atan2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (sv[SQRT_CELLS]),
        .i_ready (sr[SQRT_CELLS]),
        .i_y     (at_y),
        .i_x     (at_x),
        .o_valid (at_valid),
        .o_ready (out_rdy),
        .o_ang   (at_ang)
    );

    always_comb begin
        if (at_ang[0] > ROLL_LIM) begin
            roll_next = 16'(ROLL_LIM);
        end else if (at_ang[0] < -ROLL_LIM) begin
            roll_next = -16'(ROLL_LIM);
        end else begin
            roll_next = 16'(at_ang[0]);
        end

        pitch_neg = -(DEG_WIDTH + 1)'(at_ang[1]);
        if (pitch_neg > PITCH_LIM) begin
            pitch_next = 15'(PITCH_LIM);
        end else if (pitch_neg < -PITCH_LIM) begin
            pitch_next = -15'(PITCH_LIM);
        end else begin
            pitch_next = 15'(pitch_neg);
        end

        head_sum = EW'(at_ang[2]) + EW'(decl_reg);
        head_adj = (head_sum < 0) ? head_sum + EW'(FULL_TURN_CD) : head_sum;
        if (head_adj < 0) begin
            head_next = '0;
        end else if (head_adj > FULL_TURN_CD) begin
            head_next = 16'(FULL_TURN_CD);
        end else begin
            head_next = 16'(head_adj);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (out_rdy) begin
            ov_reg <= at_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && at_valid) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            head_reg  <= head_next;
        end
    end

    assign m_valid         = ov_reg;
    assign m_roll_angle    = roll_reg;
    assign m_pitch_angle   = pitch_reg;
    assign m_heading_angle = head_reg;

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_heading_angle <= 16'd36000)
        else $error("heading beat out of range");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_roll_angle <= 16'sd18000) && (m_roll_angle >= -16'sd18000))
        else $error("roll beat out of range");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_angle <= 15'sd9000) && (m_pitch_angle >= -15'sd9000))
        else $error("pitch beat out of range");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && !rdy2)
        else $error("input stalled with room in the first stage");

    a_reset_drop: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

endmodule

`default_nettype wire

### verif/tb_quaternion_to_euler_heading_core.sv
// Self-checking testbench for the quaternion to roll, pitch and heading core.
`default_nettype none

module tb_quaternion_to_euler_heading_core;
    import q2e_pkg::*;

    localparam int  CORE_STEPS  = 16;
    localparam int  PIPE_DEPTH  = 45 + CORE_STEPS;
    localparam int  DRAIN_WAIT  = PIPE_DEPTH + 10;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  LONG_HOLD   = 500;
    localparam longint ONE_Q28  = 64'sd1 << 26;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic        [15:0] heading;
    } angles_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic signed [15:0] cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_roll_angle;
    logic signed [14:0] m_pitch_angle;
    logic        [15:0] m_heading_angle;

    angles_t angles_q[$];
    longint  decl_shadow = 0;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    bit      gaps_on = 1'b1;
    int      stall_mode = 0;
    int      stall_phase = 0;
    bit      hold_on = 1'b0;
    event    hold_start;

    quaternion_to_euler_heading_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x), .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_roll_angle(m_roll_angle), .m_pitch_angle(m_pitch_angle),
        .m_heading_angle(m_heading_angle)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint vector_angle(longint y, longint x);
        longint base, z, xs, ys, mag;
        base = 0;
        z = 0;
        if (y == 0) return (x < 0) ? longint'(HALF_TURN) : 0;
        if (x == 0) return (y > 0) ? longint'(QUARTER_TURN) : -longint'(QUARTER_TURN);
        if (x < 0) begin
            base = (y > 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
            x = -x;
            y = -y;
        end
        mag = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        while (mag >= (64'sd1 << 29)) begin
            x = x >>> 1;
            y = y >>> 1;
            mag = mag >>> 1;
        end
        while (mag < (64'sd1 << 28)) begin
            x = x * 2;
            y = y * 2;
            mag = mag * 2;
        end
        for (int i = 0; i < CORE_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        return base + z;
    endfunction

    function automatic longint centideg(longint a);
        return (a * 36000 + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] n);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic angles_t euler_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, a11, a21, a31, a32, a33, s, roll, pitch, head;
        bit [63:0] c;
        angles_t r;
        w = qw; x = qx; y = qy; z = qz;
        a11 = ((w*w) >>> 2) + ((x*x) >>> 2) - ((y*y) >>> 2) - ((z*z) >>> 2);
        a33 = ((w*w) >>> 2) - ((x*x) >>> 2) - ((y*y) >>> 2) + ((z*z) >>> 2);
        a21 = ((w*z) >>> 1) + ((x*y) >>> 1);
        a31 = ((x*z) >>> 1) - ((w*y) >>> 1);
        a32 = ((w*x) >>> 1) + ((y*z) >>> 1);
        s = clip(a31, -ONE_Q28, ONE_Q28) * 16;
        c = int_sqrt((64'd1 << 60) - 64'(s * s));
        roll = clip(centideg(vector_angle(a32, a33)), -18000, 18000);
        pitch = clip(-centideg(vector_angle(s, longint'(c))), -9000, 9000);
        head = centideg(vector_angle(a21, a11)) + decl_shadow;
        if (head < 0) head = head + 36000;
        head = clip(head, 0, 36000);
        r.roll = roll[15:0];
        r.pitch = pitch[14:0];
        r.heading = head[15:0];
        return r;
    endfunction

    // receiver: own stall pattern, long hold on request
    always begin
        @(hold_start);
        hold_on = 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_on = 1'b0;
    end

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (hold_on) begin
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 99) >= 35);
                default: m_ready <= (stall_phase % 7) < 4;
            endcase
        end
    end

    always @(negedge aclk) begin
        angles_t exp_a;
        if (aresetn && m_valid && m_ready) begin
            if (angles_q.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                exp_a = angles_q.pop_front();
                if (m_roll_angle !== exp_a.roll) begin
                    $error("roll_angle expected %0d got %0d", exp_a.roll, m_roll_angle);
                    fail_count++;
                end
                if (m_pitch_angle !== exp_a.pitch) begin
                    $error("pitch_angle expected %0d got %0d", exp_a.pitch, m_pitch_angle);
                    fail_count++;
                end
                if (m_heading_angle !== exp_a.heading) begin
                    $error("heading_angle expected %0d got %0d", exp_a.heading,
                           m_heading_angle);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_quat(input logic signed [15:0] w, x, y, z);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_quat_w <= w;
        s_quat_x <= x;
        s_quat_y <= y;
        s_quat_z <= z;
        do @(negedge aclk); while (!s_ready);
        angles_q.push_back(euler_angles(w, x, y, z));
        @(posedge aclk);
    endtask

    task automatic drain_beats();
        s_valid <= 1'b0;
        while (angles_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_declination(input logic signed [15:0] v);
        drain_beats();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        decl_shadow = v;
    endtask

    task automatic send_random_quat();
        logic signed [15:0] q[4];
        int kind;
        kind = $urandom_range(0, 9);
        foreach (q[i]) begin
            if (kind < 4) q[i] = 16'($urandom);
            else if (kind < 8) q[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
            else q[i] = ($urandom_range(0, 1)) ? 16'sd0 : 16'($urandom);
        end
        send_quat(q[0], q[1], q[2], q[3]);
    endtask

    task automatic test_directed();
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, -16384);
        send_quat(11585, 11585, 0, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 0, 0, 11585);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(0, 32767, 0, 32767);
        send_quat(0, 32767, 0, -32768);
        send_quat(32767, 0, -32768, 0);
        send_quat(1, 0, 0, 0);
        send_quat(-1, -1, -1, -1);
        send_quat(0, 0, 16384, 16384);
        send_quat(16384, -16384, 16384, -16384);
        drain_beats();
    endtask

    task automatic test_declination_sweep();
        logic signed [15:0] decl_set[7];
        decl_set = '{16'sd18000, -16'sd18000, 16'sd32767, -16'sd32768, 16'sd0, 16'sd1, 16'sd0};
        decl_set[5] = 16'(int'($urandom_range(0, 36000)) - 18000);
        foreach (decl_set[i]) begin
            set_declination(decl_set[i]);
            stall_mode = i % 3;
            send_quat(16384, 0, 0, 0);
            send_quat(0, 0, 0, 16384);
            repeat (120) send_random_quat();
        end
        drain_beats();
    endtask

    task automatic test_random_flow();
        for (int i = 0; i < 450; i++) begin
            if (i % 100 == 0) begin
                stall_mode = $urandom_range(0, 2);
                gaps_on = $urandom_range(0, 1);
            end
            send_random_quat();
        end
        gaps_on = 1'b1;
        drain_beats();
    endtask

    task automatic test_backpressure();
        stall_mode = 0;
        gaps_on = 1'b0;
        -> hold_start;
        repeat (200) send_random_quat();
        gaps_on = 1'b1;
        drain_beats();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_declination_sweep();
        test_random_flow();
        test_backpressure();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/q2e_pkg.sv
src/q2e_sqrt_cell.sv
src/q2e_norm_cell.sv
src/q2e_cordic_cell.sv
src/q2e_atan2.sv
src/quaternion_to_euler_heading_core.sv
verif/tb_quaternion_to_euler_heading_core.sv
